/* src/rmp_pkg.sv */
// -----------------------------------------------------------------------------
// rmp_pkg
// Shared types, constants and the run encoder of the RLE marker packer.
// -----------------------------------------------------------------------------
package rmp_pkg;

  // Register reset values and fixed limits
  localparam logic [7:0]  MARK8_RESET     = 8'hFA;
  localparam logic [15:0] MARK16_RESET    = 16'hA0EA;
  localparam logic [16:0] BLOCK_LEN_RESET = 17'h10000;
  localparam logic [7:0]  EXTRA_MAX       = 8'd255;
  localparam logic [7:0]  SMALL8          = 8'd15;
  localparam logic [7:0]  SMALL16         = 8'd255;
  localparam logic [16:0] COUNT_MAX       = 17'h1FFFF;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_WIDE_MODE    = 2'd0,
    CFG_MARK8_BASE   = 2'd1,
    CFG_MARK16_BASE  = 2'd2,
    CFG_BLOCK_LENGTH = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic        wide_mode;
    logic [7:0]  mark8_base;
    logic [15:0] mark16_base;
    logic [16:0] block_length;
  } cfg_t;

  typedef struct packed {
    logic [15:0] symbol;
    logic        end_of_block;
  } in_item_t;

  typedef struct packed {
    logic [15:0] out_word;
    logic        block_done;
    logic        failed;
    logic [16:0] packed_words;
    logic        word_valid;
  } out_item_t;

  // One encoded run: up to three words
  typedef struct packed {
    logic [1:0]       nwords;
    logic [2:0][15:0] words;
  } run_t;

  // One queue entry: up to two runs plus the block status
  typedef struct packed {
    run_t        run_a;
    run_t        run_b;
    logic        eob;
    logic        failed;
    logic [16:0] count;
  } cmd_t;

  // Encode a run as literals, zero-run, small packed or general form
  function automatic run_t encode_run(input logic [15:0] sym, input logic [7:0] extra,
                                      input logic wide, input logic [15:0] base);
    logic [15:0] wmask;
    logic [15:0] s;
    logic [16:0] m1;
    logic [16:0] m3;
    logic [15:0] m2w;
    logic [7:0]  small_lim;
    logic [15:0] pk;
    run_t        r;
    wmask     = wide ? 16'hFFFF : 16'h00FF;
    s         = sym & wmask;
    m1        = {1'b0, base};
    m3        = m1 + 17'd2;
    m2w       = (base + 16'd1) & wmask;
    small_lim = wide ? SMALL16 : SMALL8;
    pk        = wide ? {extra, s[7:0]} : {8'h00, extra[3:0], s[3:0]};
    r.words   = '0;
    if (extra <= 8'd1 && ({1'b0, s} < m1 || {1'b0, s} > m3)) begin
      r.nwords   = extra[0] ? 2'd2 : 2'd1;
      r.words[0] = s;
      r.words[1] = extra[0] ? s : 16'h0000;
    end else if (s == 16'h0000) begin
      r.nwords   = 2'd2;
      r.words[0] = m3[15:0] & wmask;
      r.words[1] = {8'h00, extra};
    end else if (extra <= small_lim && s <= {8'h00, small_lim}) begin
      r.nwords   = 2'd2;
      r.words[0] = m2w;
      r.words[1] = pk;
    end else begin
      r.nwords   = 2'd3;
      r.words[0] = base & wmask;
      r.words[1] = s;
      r.words[2] = {8'h00, extra};
    end
    return r;
  endfunction

  // Add a word count with saturation
  function automatic logic [16:0] add_sat(input logic [16:0] cnt, input logic [1:0] n);
    logic [17:0] sum;
    sum = {1'b0, cnt} + {16'h0000, n};
    return sum[17] ? COUNT_MAX : sum[16:0];
  endfunction

endpackage

/* src/rmp_cmd_fifo.sv */
// -----------------------------------------------------------------------------
// rmp_cmd_fifo
// Two-entry command queue between the run tracker and the word sequencer.
// -----------------------------------------------------------------------------
module rmp_cmd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  rmp_pkg::cmd_t push_data_i,
  output logic          full_o,
  output logic          valid_o,
  input  logic          pop_i,
  output rmp_pkg::cmd_t head_o
);
  import rmp_pkg::*;

  cmd_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign head_o  = mem_q[rd_ptr_q];

  // Store entries
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

endmodule

/* src/rmp_front.sv */
// -----------------------------------------------------------------------------
// rmp_front
// Run tracker: accepts symbols, keeps the open run and the word count, decides
// run breaks and aborts, and queues the encoded runs of each beat.
// -----------------------------------------------------------------------------
module rmp_front #(
  parameter int unsigned MAX_BLOCK = 65536
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rmp_pkg::cfg_t     cfg_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  rmp_pkg::in_item_t in_data_i,
  input  logic              fifo_full_i,
  output logic              push_o,
  output rmp_pkg::cmd_t     push_data_o
);
  import rmp_pkg::*;

  localparam int unsigned LenW  = (($clog2(MAX_BLOCK + 1) > 17) ?
                                   $clog2(MAX_BLOCK + 1) : 17) + 1;
  localparam int unsigned LimW  = LenW + 1;
  localparam logic [LenW-1:0] MaxLen = LenW'(MAX_BLOCK);

  logic [15:0] run_symbol_q, run_symbol_d;
  logic [7:0]  run_extra_q, run_extra_d;
  logic        run_open_q, run_open_d;
  logic [16:0] count_q, count_d;
  logic        aborted_q, aborted_d;

  logic [15:0]        wmask, sym, base;
  logic [LenW-1:0]    len_ext, len;
  logic signed [LimW-1:0] limit, cnt1_s, cnt2_s;
  logic               accept, same, brk, extend, start, abort, b_en;
  logic [16:0]        cnt1, cnt2;
  run_t               run_old, run_b, run_none;

  assign in_ready_o = !fifo_full_i;
  assign accept     = in_valid_i && in_ready_o;

  // Mode-dependent symbol and marks
  assign wmask = cfg_i.wide_mode ? 16'hFFFF : 16'h00FF;
  assign sym   = in_data_i.symbol & wmask;
  assign base  = cfg_i.wide_mode ? cfg_i.mark16_base : {8'h00, cfg_i.mark8_base};

  // Failure limit, may go negative for tiny blocks
  assign len_ext = {{(LenW-17){1'b0}}, cfg_i.block_length};
  assign len     = (len_ext > MaxLen) ? MaxLen : len_ext;
  assign limit   = $signed({1'b0, len}) - LimW'(3);

  // Classify the beat
  assign same   = ((run_symbol_q & wmask) == sym) && (run_extra_q < EXTRA_MAX);
  assign start  = !aborted_q && !run_open_q;
  assign extend = !aborted_q && run_open_q && same;
  assign brk    = !aborted_q && run_open_q && !same;

  assign run_old = encode_run(run_symbol_q, run_extra_q, cfg_i.wide_mode, base);
  assign cnt1    = brk ? add_sat(count_q, run_old.nwords) : count_q;
  assign cnt1_s  = $signed({{(LimW-17){1'b0}}, cnt1});
  assign abort   = brk && (cnt1_s >= limit);

  // Run after this beat
  always_comb begin
    run_symbol_d = run_symbol_q;
    run_extra_d  = run_extra_q;
    run_open_d   = run_open_q;
    if (start) begin
      run_symbol_d = sym;
      run_extra_d  = 8'd0;
      run_open_d   = 1'b1;
    end else if (extend) begin
      run_extra_d  = run_extra_q + 8'd1;
    end else if (brk) begin
      run_symbol_d = sym;
      run_extra_d  = 8'd0;
      run_open_d   = !abort;
    end
  end

  // Second run: flushed on abort or at the end of the block
  assign run_b  = encode_run(run_symbol_d, run_extra_d, cfg_i.wide_mode, base);
  assign b_en   = abort || (in_data_i.end_of_block && run_open_d);
  assign cnt2   = b_en ? add_sat(cnt1, run_b.nwords) : cnt1;
  assign cnt2_s = $signed({{(LimW-17){1'b0}}, cnt2});

  // Build the queue entry, first run always in slot a
  always_comb begin
    run_none        = '0;
    push_data_o     = '0;
    push_data_o.eob = in_data_i.end_of_block;
    push_data_o.failed = (cnt2_s > limit);
    push_data_o.count  = cnt2;
    if (brk) begin
      push_data_o.run_a = run_old;
      push_data_o.run_b = b_en ? run_b : run_none;
    end else begin
      push_data_o.run_a = b_en ? run_b : run_none;
      push_data_o.run_b = run_none;
    end
  end

  assign push_o = accept && (brk || b_en || in_data_i.end_of_block);

  // Next count and abort flag; the registers clear them at block end
  always_comb begin
    count_d   = count_q;
    aborted_d = aborted_q;
    if (accept) begin
      count_d   = cnt2;
      aborted_d = aborted_q || abort;
    end
  end

  // Hold run state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_symbol_q <= '0;
      run_extra_q  <= '0;
      run_open_q   <= 1'b0;
      count_q      <= '0;
      aborted_q    <= 1'b0;
    end else if (accept) begin
      if (in_data_i.end_of_block) begin
        run_symbol_q <= '0;
        run_extra_q  <= '0;
        run_open_q   <= 1'b0;
        count_q      <= '0;
        aborted_q    <= 1'b0;
      end else begin
        run_symbol_q <= run_symbol_d;
        run_extra_q  <= run_extra_d;
        run_open_q   <= run_open_d;
        count_q      <= count_d;
        aborted_q    <= aborted_d;
      end
    end
  end

endmodule

/* src/rmp_back.sv */
// -----------------------------------------------------------------------------
// rmp_back
// Word sequencer: walks the queued runs one word per beat into the output
// register and puts the block status on the last beat of a block.
// -----------------------------------------------------------------------------
module rmp_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               head_valid_i,
  input  rmp_pkg::cmd_t      head_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output rmp_pkg::out_item_t out_data_o
);
  import rmp_pkg::*;

  logic      slot_q, slot_d;
  logic [1:0] idx_q, idx_d;
  logic      out_valid_q;
  out_item_t out_q, out_d;
  run_t      cur;
  logic      status_only, run_last, last, fire, done;

  // Select current word
  assign cur         = slot_q ? head_i.run_b : head_i.run_a;
  assign status_only = (head_i.run_a.nwords == 2'd0);
  assign run_last    = ((idx_q + 2'd1) == cur.nwords);
  assign last        = status_only || (run_last && (slot_q || head_i.run_b.nwords == 2'd0));
  assign fire        = head_valid_i && (!out_valid_q || out_ready_i);
  assign pop_o       = fire && last;
  assign done        = last && head_i.eob;

  always_comb begin
    out_d.out_word     = status_only ? 16'h0000 : cur.words[idx_q];
    out_d.word_valid   = !status_only;
    out_d.block_done   = done;
    out_d.failed       = done && head_i.failed;
    out_d.packed_words = done ? head_i.count : 17'd0;
  end

  // Advance word index and run slot
  always_comb begin
    slot_d = slot_q;
    idx_d  = idx_q;
    if (fire) begin
      if (last) begin
        slot_d = 1'b0;
        idx_d  = 2'd0;
      end else if (run_last) begin
        slot_d = 1'b1;
        idx_d  = 2'd0;
      end else begin
        idx_d  = idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q      <= 1'b0;
      idx_q       <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      slot_q <= slot_d;
      idx_q  <= idx_d;
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Output payload register
  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* src/rle_marker_packer_unit.sv */
// -----------------------------------------------------------------------------
// rle_marker_packer_unit
// Run-length packer with escape marks, 8- or 16-bit symbols.
// -----------------------------------------------------------------------------
// The input side takes one symbol per cycle whenever the two-entry command
// queue has room; the run tracker decides breaks, aborts and the word count in
// that same cycle. Results leave the word sequencer one word per cycle while
// the output is ready, and the words an item causes are: none for a symbol
// that opens or extends a run without ending the block, one to three for an
// ordinary run break, up to six when a break aborts the block or meets the
// end of the block, and a single beat without a word for the status-only end
// of an aborted block. Sustained throughput therefore follows the output word
// rate. The first word of an item passes through the command queue, where it
// can wait while the sequencer is busy, and then through the output register.
// Configuration registers are written through the plain write port and take
// effect at once.
// -----------------------------------------------------------------------------
module rle_marker_packer_unit #(
  parameter int unsigned MAX_BLOCK = 65536
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [16:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  rmp_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output rmp_pkg::out_item_t out_data_o
);
  import rmp_pkg::*;

  cfg_t cfg_q;
  logic cmd_push, fifo_full, head_valid, pop;
  cmd_t cmd_in, cmd_head;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.wide_mode    <= 1'b0;
      cfg_q.mark8_base   <= MARK8_RESET;
      cfg_q.mark16_base  <= MARK16_RESET;
      cfg_q.block_length <= BLOCK_LEN_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_WIDE_MODE:    cfg_q.wide_mode    <= cfg_wdata_i[0];
        CFG_MARK8_BASE:   cfg_q.mark8_base   <= cfg_wdata_i[7:0];
        CFG_MARK16_BASE:  cfg_q.mark16_base  <= cfg_wdata_i[15:0];
        CFG_BLOCK_LENGTH: cfg_q.block_length <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  rmp_front #(
    .MAX_BLOCK (MAX_BLOCK)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .fifo_full_i (fifo_full),
    .push_o      (cmd_push),
    .push_data_o (cmd_in)
  );

  rmp_cmd_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (cmd_push),
    .push_data_i (cmd_in),
    .full_o      (fifo_full),
    .valid_o     (head_valid),
    .pop_i       (pop),
    .head_o      (cmd_head)
  );

  rmp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (cmd_head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o)
  );

  // Never push into a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd_push |-> !fifo_full)
    else $error("command pushed into full queue");

  // A beat without a word closes its block
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.word_valid |-> out_data_o.block_done)
    else $error("status-only beat not at block end");

  // Status fields stay clear before the last beat of a block
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.block_done |->
      !out_data_o.failed && out_data_o.packed_words == 17'd0)
    else $error("status on a non-final beat");

endmodule
